// File: hw/rtl/sspl_pkg.sv
`timescale 1ns / 1ps

package sspl_pkg;

    localparam int NUM_LISTS = 32;
    localparam int CAPACITY  = 16;

    localparam int LIST_W  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ADDR_W  = LIST_W + SLOT_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    localparam int ID_W    = 8;
    localparam int PRIO_W  = 16;
    localparam int ENTRY_W = ID_W + PRIO_W;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_ENTRY = 2'd2;
    localparam logic [1:0] STATUS_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SHIFT,
        ST_INS_PLACE,
        ST_DUMP,
        ST_RESP
    } state_t;

endpackage

// File: hw/rtl/stable_sorted_priority_lists.sv
`timescale 1ns / 1ps

// Bank of NUM_LISTS sorted lists of up to CAPACITY (id, priority) entries, held
// in one synchronous entry memory addressed by {list, slot}, with per-list
// counts in flip-flops cleared by reset. An insert walks the list from its
// tail, reading one entry a cycle and moving every entry of higher priority one
// slot up until the new entry drops into place after all entries of lower or
// equal priority, and gives one result beat. A dump streams the list from its
// head, one beat per cycle while the result side does not stall, marks the
// final beat with last and empties the list. Drops, empty dumps and out-of-range
// list indexes give one status-only beat marked last. The block takes one item
// at a time: in_stall is high while an item is in work, but a finished result
// may wait in the output register while the next item is accepted.
module stable_sorted_priority_lists
    import sspl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     kind,
    input  logic [4:0]               list_index,
    input  logic [ID_W-1:0]          task_id,
    input  logic signed [PRIO_W-1:0] priority_req,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [1:0]               status,
    output logic [ID_W-1:0]          task_id_res,
    output logic signed [PRIO_W-1:0] priority_res,
    output logic                     last
);

    state_t state_reg, state_next;

    logic [LIST_W-1:0]        li_reg, li_next;
    logic [SLOT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [ID_W-1:0]          id_reg, id_next;
    logic signed [PRIO_W-1:0] prio_reg, prio_next;
    logic [1:0]               resp_status_reg, resp_status_next;

    logic                     res_valid_reg, res_valid_next;
    logic [1:0]               status_reg, status_next;
    logic [ID_W-1:0]          task_id_res_reg, task_id_res_next;
    logic signed [PRIO_W-1:0] priority_res_reg, priority_res_next;
    logic                     last_reg, last_next;

    logic [CNT_W-1:0]   count_reg [NUM_LISTS];
    logic               cnt_we;
    logic [CNT_W-1:0]   cnt_wdata;

    logic [ENTRY_W-1:0] entry_mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic                     in_accept;
    logic                     list_ok;
    logic [LIST_W-1:0]        list_sel;
    logic [CNT_W-1:0]         n_cur;
    logic                     ins_drop;
    logic                     dmp_empty;
    logic                     out_free;
    logic                     out_load;
    logic                     shift_up;
    logic                     dump_last;
    logic signed [PRIO_W-1:0] rd_prio;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign list_ok   = (32'(list_index) < NUM_LISTS);
    assign list_sel  = LIST_W'(list_index);
    assign n_cur     = list_ok ? count_reg[list_sel] : '0;
    assign ins_drop  = !list_ok || (32'(n_cur) >= CAPACITY);
    assign dmp_empty = !list_ok || (n_cur == '0);

    assign out_free  = !res_valid_reg || !res_stall;
    assign rd_prio   = $signed(rd_data_reg[PRIO_W-1:0]);
    // entries of higher priority move up, ties stay ahead of the new entry
    assign shift_up  = (rd_prio > prio_reg);
    assign dump_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (kind == KIND_INSERT)
                    begin
                        if (ins_drop)
                            state_next = ST_RESP;
                        else if (n_cur == '0)
                            state_next = ST_INS_PLACE;
                        else
                            state_next = ST_INS_SHIFT;
                    end
                    else
                    begin
                        state_next = dmp_empty ? ST_RESP : ST_DUMP;
                    end
                end
            end
            ST_INS_SHIFT:
            begin
                if (!shift_up)
                    state_next = ST_RESP;
                else if (idx_reg == '0)
                    state_next = ST_INS_PLACE;
            end
            ST_INS_PLACE:
            begin
                state_next = ST_RESP;
            end
            ST_DUMP:
            begin
                if (out_free && dump_last)
                    state_next = ST_IDLE;
            end
            ST_RESP:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory, count and datapath control
    always_comb
    begin
        li_next          = li_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        id_next          = id_reg;
        prio_next        = prio_reg;
        resp_status_next = resp_status_reg;
        cnt_we           = 1'b0;
        cnt_wdata        = '0;
        rd_en            = 1'b0;
        rd_addr          = '0;
        mem_we           = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;
        out_load         = 1'b0;
        status_next      = status_reg;
        task_id_res_next = task_id_res_reg;
        priority_res_next = priority_res_reg;
        last_next        = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    li_next   = list_sel;
                    id_next   = task_id;
                    prio_next = priority_req;
                    cnt_next  = n_cur;
                    idx_next  = '0;
                    if (kind == KIND_INSERT)
                    begin
                        resp_status_next = ins_drop ? STATUS_FULL : STATUS_OK;
                        if (!ins_drop)
                        begin
                            cnt_we    = 1'b1;
                            cnt_wdata = n_cur + CNT_W'(1);
                            if (n_cur != '0)
                            begin
                                idx_next = SLOT_W'(n_cur - CNT_W'(1));
                                rd_en    = 1'b1;
                                rd_addr  = {list_sel, SLOT_W'(n_cur - CNT_W'(1))};
                            end
                        end
                    end
                    else
                    begin
                        resp_status_next = STATUS_EMPTY;
                        if (!dmp_empty)
                        begin
                            cnt_we    = 1'b1;
                            cnt_wdata = '0;
                            rd_en     = 1'b1;
                            rd_addr   = {list_sel, SLOT_W'(0)};
                        end
                    end
                end
            end
            ST_INS_SHIFT:
            begin
                mem_we  = 1'b1;
                wr_addr = {li_reg, idx_reg + SLOT_W'(1)};
                if (shift_up)
                begin
                    wr_data = rd_data_reg;
                    if (idx_reg != '0)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = {li_reg, idx_reg - SLOT_W'(1)};
                        idx_next = idx_reg - SLOT_W'(1);
                    end
                end
                else
                begin
                    wr_data = {id_reg, prio_reg};
                end
            end
            ST_INS_PLACE:
            begin
                mem_we  = 1'b1;
                wr_addr = {li_reg, idx_reg};
                wr_data = {id_reg, prio_reg};
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    out_load          = 1'b1;
                    status_next       = STATUS_ENTRY;
                    task_id_res_next  = rd_data_reg[ENTRY_W-1:PRIO_W];
                    priority_res_next = rd_prio;
                    last_next         = dump_last;
                    if (!dump_last)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = {li_reg, idx_reg + SLOT_W'(1)};
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_load          = 1'b1;
                    status_next       = resp_status_reg;
                    task_id_res_next  = '0;
                    priority_res_next = '0;
                    last_next         = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid_next = out_load || (res_valid_reg && res_stall);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= entry_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        li_reg           <= li_next;
        idx_reg          <= idx_next;
        cnt_reg          <= cnt_next;
        id_reg           <= id_next;
        prio_reg         <= prio_next;
        resp_status_reg  <= resp_status_next;
        status_reg       <= status_next;
        task_id_res_reg  <= task_id_res_next;
        priority_res_reg <= priority_res_next;
        last_reg         <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++)
                count_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (cnt_we)
                count_reg[li_next] <= cnt_wdata;
        end
    end

    assign res_valid    = res_valid_reg;
    assign status       = status_reg;
    assign task_id_res  = task_id_res_reg;
    assign priority_res = priority_res_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (32'(n_cur) <= CAPACITY))
        else $error("list count beyond capacity");

    a_no_addr_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && rd_en) |-> (wr_addr != rd_addr))
        else $error("entry read and write hit the same slot");

    a_dump_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP && out_load && last_next) |=> (state_reg == ST_IDLE))
        else $error("dump did not finish on its last beat");

    a_last_beat_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && status_next != STATUS_ENTRY) |-> last_next)
        else $error("status-only result without last");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb
    import sspl_pkg::*;
();

    typedef struct {
        logic [1:0]               status;
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
        logic                     last;
    } list_beat_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     kind = KIND_INSERT;
    logic [4:0]               list_index = '0;
    logic [ID_W-1:0]          task_id = '0;
    logic signed [PRIO_W-1:0] priority_req = '0;
    logic                     res_valid;
    logic                     res_stall = 1'b0;
    logic [1:0]               status;
    logic [ID_W-1:0]          task_id_res;
    logic signed [PRIO_W-1:0] priority_res;
    logic                     last;

    // predicted contents of every list
    logic [ID_W-1:0]          list_ids   [NUM_LISTS][CAPACITY];
    logic signed [PRIO_W-1:0] list_prios [NUM_LISTS][CAPACITY];
    int                       list_fill  [NUM_LISTS];
    list_beat_t               pending_beats[$];

    logic [4:0] hot_lists [4];
    bit         quiet = 1'b0;
    int         errors = 0;
    int         n_inserts = 0;
    int         n_refused = 0;
    int         n_dumps = 0;
    int         n_dumped = 0;

    stable_sorted_priority_lists dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .list_index   (list_index),
        .task_id      (task_id),
        .priority_req (priority_req),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .status       (status),
        .task_id_res  (task_id_res),
        .priority_res (priority_res),
        .last         (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic list_beat_t make_beat(input logic [1:0] st, input logic [ID_W-1:0] id,
                                             input logic signed [PRIO_W-1:0] pr,
                                             input logic lst);
        list_beat_t b;
        b.status = st;
        b.id     = id;
        b.prio   = pr;
        b.last   = lst;
        return b;
    endfunction

    // works out the beats one accepted item gives and updates the lists
    task automatic apply_to_lists(input logic k, input logic [4:0] li,
                                  input logic [ID_W-1:0] id,
                                  input logic signed [PRIO_W-1:0] pr);
        int n;
        int pos;
        n = list_fill[li];
        if (k == KIND_INSERT)
        begin
            n_inserts++;
            if (n >= CAPACITY)
            begin
                n_refused++;
                pending_beats.push_back(make_beat(STATUS_FULL, '0, '0, 1'b1));
            end
            else
            begin
                // new entry goes after everything of lower or equal priority
                pos = 0;
                while (pos < n && list_prios[li][pos] <= pr)
                    pos++;
                for (int i = n; i > pos; i--)
                begin
                    list_ids[li][i]   = list_ids[li][i-1];
                    list_prios[li][i] = list_prios[li][i-1];
                end
                list_ids[li][pos]   = id;
                list_prios[li][pos] = pr;
                list_fill[li]       = n + 1;
                pending_beats.push_back(make_beat(STATUS_OK, '0, '0, 1'b1));
            end
        end
        else
        begin
            n_dumps++;
            if (n == 0)
                pending_beats.push_back(make_beat(STATUS_EMPTY, '0, '0, 1'b1));
            for (int i = 0; i < n; i++)
                pending_beats.push_back(make_beat(STATUS_ENTRY, list_ids[li][i],
                                                  list_prios[li][i], i == n - 1));
            n_dumped += n;
            list_fill[li] = 0;
        end
    endtask

    task automatic send_item(input logic k, input logic [4:0] li,
                             input logic [ID_W-1:0] id,
                             input logic signed [PRIO_W-1:0] pr);
        if (!quiet && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 14)
                @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        list_index   <= li;
        task_id      <= id;
        priority_req <= pr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_to_lists(k, li, id, pr);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [PRIO_W-1:0] pick_prio();
        case ($urandom_range(3))
            // narrow range so that ties are common
            0: return PRIO_W'(int'($urandom_range(6)) - 3);
            1: return $urandom_range(1) ? {1'b0, {(PRIO_W-1){1'b1}}}
                                        : {1'b1, {(PRIO_W-1){1'b0}}};
            default: return PRIO_W'($urandom);
        endcase
    endfunction

    task automatic send_random_item(input int dump_pct);
        logic [4:0] li;
        logic       k;
        li = ($urandom_range(99) < 75) ? hot_lists[$urandom_range(3)] : 5'($urandom_range(31));
        k  = ($urandom_range(99) < dump_pct) ? KIND_DUMP : KIND_INSERT;
        send_item(k, li, ID_W'($urandom), pick_prio());
    endtask

    task automatic check_beat();
        list_beat_t want;
        if (pending_beats.size() == 0)
        begin
            $error("result beat with nothing expected: status %0d id %0d", status, task_id_res);
            errors++;
            return;
        end
        want = pending_beats.pop_front();
        if (status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
        end
        if (task_id_res !== want.id)
        begin
            $error("task_id_res: expected %0d, got %0d", want.id, task_id_res);
            errors++;
        end
        if (priority_res !== want.prio)
        begin
            $error("priority_res: expected %0d, got %0d", want.prio, priority_res);
            errors++;
        end
        if (last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, last);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            check_beat();
        res_stall <= !quiet && ($urandom_range(99) < 14);
    end

    // extremes, ties at both ends, a full list and empty dumps
    task automatic test_directed();
        logic signed [PRIO_W-1:0] prios [CAPACITY] = '{
            16'sd0, -16'sd32768, 16'sd32767, 16'sd5, -16'sd1, 16'sd5, 16'sd1, 16'sd21845,
            -16'sd21846, 16'sd5, 16'sd32767, -16'sd32768, 16'sd0, 16'sd100, -16'sd100, 16'sd7};
        logic [ID_W-1:0] ids [CAPACITY] = '{
            8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01, 8'h02, 8'h03, 8'h04,
            8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C};
        send_item(KIND_DUMP, 5'd0, '0, '0);
        for (int i = 0; i < CAPACITY; i++)
            send_item(KIND_INSERT, 5'd31, ids[i], prios[i]);
        send_item(KIND_INSERT, 5'd31, 8'h3C, 16'sd0);
        send_item(KIND_DUMP, 5'd31, '0, '0);
        send_item(KIND_DUMP, 5'd31, 8'hFF, -16'sd1);
        send_item(KIND_INSERT, 5'd0, 8'hC3, -16'sd1);
        send_item(KIND_DUMP, 5'd0, '0, '0);
    endtask

    // back to back traffic, neither side idling
    task automatic test_burst_no_idle();
        quiet = 1'b1;
        for (int i = 0; i < 4; i++)
            hot_lists[i] = 5'($urandom_range(31));
        for (int i = 0; i < 40; i++)
            send_random_item(20);
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 4; i++)
            hot_lists[i] = 5'($urandom_range(31));
        for (int i = 0; i < 116; i++)
        begin
            if (i == 58)
                hold_until_drained();
            send_random_item(15);
        end
    endtask

    task automatic test_flush_all();
        for (int i = 0; i < NUM_LISTS; i++)
            send_item(KIND_DUMP, 5'(i), ID_W'($urandom), pick_prio());
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_burst_no_idle();
        test_random_traffic();
        test_flush_all();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("%0d inserts (%0d refused as full), %0d dumps giving %0d entries",
                 n_inserts, n_refused, n_dumps, n_dumped);
        $display("ties, priority extremes, full and empty lists, all %0d lists flushed",
                 NUM_LISTS);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("timed out waiting for the block");
        $display("== FAIL ==");
        $finish;
    end

endmodule
